// ===== rtl/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants of the fisheye remap address generator.
// ----------------------------------------------------------------------------
package fra_pkg;

    localparam int COORD_BITS     = 12;
    localparam int SQRT_FRAC_BITS = 8;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    typedef struct packed {
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
    } in_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_x;
        logic [COORD_BITS-1:0] src_y;
        logic                  source_inside;
    } out_word_t;

endpackage

// ===== rtl/fra_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fra_sqrt_cell
// One digit of a pipelined integer square root; carries a side word along.
// ----------------------------------------------------------------------------
module fra_sqrt_cell #(
    parameter int RT_W   = 23,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  logic [2*RT_W-1:0]   rad_in,
    input  logic [RT_W+1:0]     rem_in,
    input  logic [RT_W-1:0]     root_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid_out,
    output logic [2*RT_W-1:0]   rad_out,
    output logic [RT_W+1:0]     rem_out,
    output logic [RT_W-1:0]     root_out,
    output logic [SIDE_W-1:0]   side_out
);

    logic              valid_reg;
    logic [2*RT_W-1:0] rad_reg, rad_next;
    logic [RT_W+1:0]   rem_reg, rem_next;
    logic [RT_W-1:0]   root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;
    logic [RT_W+1:0]   cur;
    logic [RT_W+1:0]   trial;

    always_comb
    begin
        cur   = {rem_in[RT_W-1:0], rad_in[2*RT_W-1 -: 2]};
        trial = {root_in, 2'b01};
        rad_next = {rad_in[2*RT_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            rem_next  = cur - trial;
            root_next = {root_in[RT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cur;
            root_next = {root_in[RT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

// ===== rtl/fra_div_cell.sv =====
// ----------------------------------------------------------------------------
// fra_div_cell
// One quotient bit of two restoring dividers sharing a divisor.
// ----------------------------------------------------------------------------
module fra_div_cell #(
    parameter int N_W    = 29,
    parameter int D_W    = 16,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [D_W-1:0]    divisor,
    input  logic [N_W-1:0]    num_x_in,
    input  logic [N_W-1:0]    num_y_in,
    input  logic [D_W:0]      rem_x_in,
    input  logic [D_W:0]      rem_y_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [N_W-1:0]    num_x_out,
    output logic [N_W-1:0]    num_y_out,
    output logic [D_W:0]      rem_x_out,
    output logic [D_W:0]      rem_y_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    logic [N_W-1:0]    num_x_reg, num_x_next, num_y_reg, num_y_next;
    logic [D_W:0]      rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [SIDE_W-1:0] side_reg;
    logic [D_W:0]      cur_x, cur_y, dext;
    logic              ge_x, ge_y;

    always_comb
    begin
        dext  = {1'b0, divisor};
        cur_x = {rem_x_in[D_W-1:0], num_x_in[N_W-1]};
        cur_y = {rem_y_in[D_W-1:0], num_y_in[N_W-1]};
        ge_x  = (cur_x >= dext);
        ge_y  = (cur_y >= dext);
        rem_x_next = ge_x ? (cur_x - dext) : cur_x;
        rem_y_next = ge_y ? (cur_y - dext) : cur_y;
        num_x_next = {num_x_in[N_W-2:0], ge_x};
        num_y_next = {num_y_in[N_W-2:0], ge_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        num_x_reg <= num_x_next;
        num_y_reg <= num_y_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        side_reg  <= side_in;
    end

    assign valid_out = valid_reg;
    assign num_x_out = num_x_reg;
    assign num_y_out = num_y_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign side_out  = side_reg;

endmodule

// ===== rtl/fisheye_remap_address_top.sv =====
// ----------------------------------------------------------------------------
// fisheye_remap_address_top
// Source address generator for a fisheye warp, one pixel per clock.
// ----------------------------------------------------------------------------
// A destination word on item is taken at each clock edge with start high;
// busy is always low, so a new word may follow every cycle. Each word gives
// one result word on result, marked by done for one cycle; the receiver
// cannot stall it. A word passes the register for the offset squares, the
// square-root chain with one cell per root bit, the register for the two
// products, the divider chain with one cell per quotient bit and the
// register for the centre add and bounds check. Throughput is one word per
// cycle. Registers are written through wr_en, wr_index and wr_data; the
// user must write them only while no word is in flight, as the block does
// not enforce it. Reset empties the chains and restores register defaults.
// ----------------------------------------------------------------------------
module fisheye_remap_address_top #(
    parameter int COORD_BITS     = fra_pkg::COORD_BITS,
    parameter int SQRT_FRAC_BITS = fra_pkg::SQRT_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fra_pkg::in_word_t              item,
    output logic                           done,
    output fra_pkg::out_word_t             result,
    input  logic                           wr_en,
    input  logic [fra_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [fra_pkg::CFG_W-1:0]      wr_data
);

    localparam int CB     = COORD_BITS;
    localparam int F      = SQRT_FRAC_BITS;
    localparam int MAG_W  = ((CB > 13) ? CB : 13) + 1;
    localparam int S_W    = 2 * MAG_W + 1;
    localparam int SS_W   = S_W + 2 * F;
    localparam int RT_W   = (SS_W + 1) / 2;
    localparam int P_W    = MAG_W + RT_W;
    localparam int N_W    = P_W - F;
    localparam int D_W    = 16;
    localparam int SX_W   = N_W + 2;
    localparam int SQ_SIDE_W  = 2 * CB + 2 + 2 * MAG_W;
    localparam int DV_SIDE_W  = 2 * CB + 2;
    localparam int OW     = fra_pkg::COORD_BITS;

    // configuration registers
    logic signed [13:0] cx_reg, cy_reg;
    logic signed [15:0] r_reg;
    logic [12:0]        w_reg, h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            r_reg  <= 16'sd2;
            w_reg  <= 13'd4096;
            h_reg  <= 13'd4096;
        end
        else if (wr_en)
        begin
            case (wr_index)
                fra_pkg::REG_CENTER_X:     cx_reg <= wr_data[13:0];
                fra_pkg::REG_CENTER_Y:     cy_reg <= wr_data[13:0];
                fra_pkg::REG_RADIUS_SCALE: r_reg  <= wr_data;
                fra_pkg::REG_IMAGE_WIDTH:  w_reg  <= wr_data[12:0];
                fra_pkg::REG_IMAGE_HEIGHT: h_reg  <= wr_data[12:0];
                default: ;
            endcase
        end
    end

    logic          div_neg;
    logic [D_W-1:0] div_mag;
    logic [16:0]   r_abs;

    always_comb
    begin
        div_neg = r_reg[15];
        r_abs   = r_reg[15] ? (17'd0 - {r_reg[15], r_reg}) : {1'b0, r_reg};
        div_mag = (r_reg == 16'sd0) ? D_W'(1) : r_abs[D_W-1:0];
    end

    // stage 0: offsets and squared length
    logic [CB-1:0]        x_in, y_in;
    logic signed [MAG_W:0] dx, dy;
    logic [MAG_W-1:0]     dxm, dym;

    always_comb
    begin
        x_in = item.dest_x[CB-1:0];
        y_in = item.dest_y[CB-1:0];
        dx   = $signed({1'b0, (MAG_W)'(x_in)}) - (MAG_W+1)'(cx_reg);
        dy   = $signed({1'b0, (MAG_W)'(y_in)}) - (MAG_W+1)'(cy_reg);
        dxm  = dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
        dym  = dy[MAG_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    end

    logic                 v0_reg;
    logic [S_W-1:0]       s0_reg;
    logic [SQ_SIDE_W-1:0] side0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg    <= S_W'(dxm * dxm) + S_W'(dym * dym);
        side0_reg <= {x_in, y_in, dx[MAG_W], dy[MAG_W], dxm, dym};
    end

    // square-root chain
    logic                 sq_v    [RT_W+1];
    logic [2*RT_W-1:0]    sq_rad  [RT_W+1];
    logic [RT_W+1:0]      sq_rem  [RT_W+1];
    logic [RT_W-1:0]      sq_root [RT_W+1];
    logic [SQ_SIDE_W-1:0] sq_side [RT_W+1];

    assign sq_v[0]    = v0_reg;
    assign sq_rad[0]  = (2*RT_W)'({s0_reg, {(2*F+1){1'b0}}} >> 1);
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = side0_reg;

    for (genvar i = 0; i < RT_W; i++)
    begin : g_sqrt
        fra_sqrt_cell #(
            .RT_W   (RT_W),
            .SIDE_W (SQ_SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_v[i]),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .side_in   (sq_side[i]),
            .valid_out (sq_v[i+1]),
            .rad_out   (sq_rad[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // products
    logic [MAG_W-1:0]     m_dxm, m_dym;
    logic [DV_SIDE_W-1:0] m_side;
    logic [P_W-1:0]       px, py;

    always_comb
    begin
        m_dym  = sq_side[RT_W][MAG_W-1:0];
        m_dxm  = sq_side[RT_W][2*MAG_W-1:MAG_W];
        m_side = sq_side[RT_W][SQ_SIDE_W-1:2*MAG_W];
        px     = P_W'(m_dxm) * P_W'(sq_root[RT_W]);
        py     = P_W'(m_dym) * P_W'(sq_root[RT_W]);
    end

    logic                 vm_reg;
    logic [N_W-1:0]       nx_reg, ny_reg;
    logic [DV_SIDE_W-1:0] sidem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else
        begin
            vm_reg <= sq_v[RT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg    <= px[P_W-1:F];
        ny_reg    <= py[P_W-1:F];
        sidem_reg <= m_side;
    end

    // divider chain
    logic                 dv_v    [N_W+1];
    logic [N_W-1:0]       dv_nx   [N_W+1];
    logic [N_W-1:0]       dv_ny   [N_W+1];
    logic [D_W:0]         dv_rx   [N_W+1];
    logic [D_W:0]         dv_ry   [N_W+1];
    logic [DV_SIDE_W-1:0] dv_side [N_W+1];

    assign dv_v[0]    = vm_reg;
    assign dv_nx[0]   = nx_reg;
    assign dv_ny[0]   = ny_reg;
    assign dv_rx[0]   = '0;
    assign dv_ry[0]   = '0;
    assign dv_side[0] = sidem_reg;

    for (genvar j = 0; j < N_W; j++)
    begin : g_div
        fra_div_cell #(
            .N_W    (N_W),
            .D_W    (D_W),
            .SIDE_W (DV_SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dv_v[j]),
            .divisor   (div_mag),
            .num_x_in  (dv_nx[j]),
            .num_y_in  (dv_ny[j]),
            .rem_x_in  (dv_rx[j]),
            .rem_y_in  (dv_ry[j]),
            .side_in   (dv_side[j]),
            .valid_out (dv_v[j+1]),
            .num_x_out (dv_nx[j+1]),
            .num_y_out (dv_ny[j+1]),
            .rem_x_out (dv_rx[j+1]),
            .rem_y_out (dv_ry[j+1]),
            .side_out  (dv_side[j+1])
        );
    end

    // centre add and bounds check
    logic [CB-1:0]        fx, fy;
    logic                 fnx, fny;
    logic signed [SX_W-1:0] qx, qy, sx, sy, wl, hl;
    logic [13:0]          alim, wlim, hlim;
    logic                 in_image;
    fra_pkg::out_word_t   res_next, res_reg;
    logic                 done_reg;

    always_comb
    begin
        fx   = dv_side[N_W][DV_SIDE_W-1 -: CB];
        fy   = dv_side[N_W][CB+1 -: CB];
        fnx  = dv_side[N_W][1];
        fny  = dv_side[N_W][0];
        qx   = $signed({2'b00, dv_nx[N_W]});
        qy   = $signed({2'b00, dv_ny[N_W]});
        if (fnx != div_neg)
        begin
            qx = -qx;
        end
        if (fny != div_neg)
        begin
            qy = -qy;
        end
        sx   = qx + SX_W'(cx_reg);
        sy   = qy + SX_W'(cy_reg);
        alim = 14'(1) << CB;
        wlim = ({1'b0, w_reg} > alim) ? alim : {1'b0, w_reg};
        hlim = ({1'b0, h_reg} > alim) ? alim : {1'b0, h_reg};
        wl   = $signed(SX_W'(wlim));
        hl   = $signed(SX_W'(hlim));
        in_image = !sx[SX_W-1] && (sx < wl) && !sy[SX_W-1] && (sy < hl);
        if (in_image)
        begin
            res_next.src_x = OW'(sx[CB-1:0]);
            res_next.src_y = OW'(sy[CB-1:0]);
        end
        else
        begin
            res_next.src_x = OW'(fx);
            res_next.src_y = OW'(fy);
        end
        res_next.source_inside = in_image;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v[N_W];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = res_reg;

endmodule
